// ===== sv/itoa_pkg.sv =====
package itoa_pkg;

  // Width of the number that is converted; the input field stays 64 bits.
  localparam int VALUE_WIDTH = 64;
  localparam int FIELD_W     = 64;

  // Decimal digits needed for 2^VALUE_WIDTH - 1 (floor(W * log10 2) + 1).
  localparam int DEC_DIGITS  = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int BCD_W       = 4 * DEC_DIGITS;
  localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
  localparam int REM_W       = $clog2(DEC_DIGITS + 1);

  localparam logic [7:0] MINUS_CHAR = 8'h2D;

  localparam logic [7:0] GLYPHS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  typedef logic [VALUE_WIDTH-1:0] val_t;
  typedef logic [BCD_W-1:0]       bcd_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [REM_W-1:0]       rem_t;

  typedef struct packed {
    logic [FIELD_W-1:0] value;
    logic               use_hex;
    logic               is_signed;
  } num_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } chr_t;

  // Converter to emitter hand-off: digit string, most significant digit at the top.
  typedef struct packed {
    logic valid;
    logic neg;
    bcd_t digits;
  } conv_out_t;

endpackage

// ===== sv/itoa_conv.sv =====
module itoa_conv (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 num_valid,
  output logic                 num_stall,
  input  itoa_pkg::num_t       num,
  output itoa_pkg::conv_out_t  conv,
  input  logic                 conv_take
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]         state;
  logic [1:0]         state_next;
  itoa_pkg::val_t     bin;
  itoa_pkg::val_t     bin_next;
  itoa_pkg::bcd_t     bcd;
  itoa_pkg::bcd_t     bcd_next;
  itoa_pkg::bcd_t     adj;
  itoa_pkg::cnt_t     cnt;
  itoa_pkg::cnt_t     cnt_next;
  logic               neg;
  logic               neg_next;
  itoa_pkg::val_t     v;
  itoa_pkg::val_t     mag;
  logic               v_neg;
  logic               accept;

  assign num_stall = (state != ST_IDLE);
  assign accept    = num_valid && (state == ST_IDLE);

  assign v     = num.value[itoa_pkg::VALUE_WIDTH-1:0];
  assign v_neg = !num.use_hex && num.is_signed && v[itoa_pkg::VALUE_WIDTH-1];
  assign mag   = v_neg ? itoa_pkg::val_t'(~v + itoa_pkg::val_t'(1)) : v;

  // Double dabble: add three to every BCD digit of five or more, then shift one bit in.
  always_comb begin
    adj = bcd;
    for (int i = 0; i < itoa_pkg::DEC_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
  end

  always_comb begin
    state_next = state;
    bin_next   = bin;
    bcd_next   = bcd;
    cnt_next   = cnt;
    neg_next   = neg;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          neg_next = v_neg;
          bin_next = mag;
          cnt_next = itoa_pkg::cnt_t'(itoa_pkg::VALUE_WIDTH);
          if (num.use_hex) begin
            bcd_next   = itoa_pkg::bcd_t'(mag);
            state_next = ST_DONE;
          end else begin
            bcd_next   = '0;
            state_next = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        bcd_next = {adj[itoa_pkg::BCD_W-2:0], bin[itoa_pkg::VALUE_WIDTH-1]};
        bin_next = {bin[itoa_pkg::VALUE_WIDTH-2:0], 1'b0};
        cnt_next = cnt - itoa_pkg::cnt_t'(1);
        if (cnt == itoa_pkg::cnt_t'(1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (conv_take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    bin <= bin_next;
    bcd <= bcd_next;
    cnt <= cnt_next;
    neg <= neg_next;
  end

  assign conv.valid  = (state == ST_DONE);
  assign conv.neg    = neg;
  assign conv.digits = bcd;

  a_run_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (cnt != '0))
    else $error("conversion running with zero bits left");

  a_hex_direct: assert property (@(posedge clk) disable iff (rst)
    (accept && num.use_hex) |=> (state == ST_DONE))
    else $error("hex item did not load straight to done");

  a_take_done: assert property (@(posedge clk) disable iff (rst)
    conv_take |-> (state == ST_DONE))
    else $error("digits taken before conversion finished");

endmodule

// ===== sv/itoa_emit.sv =====
module itoa_emit (
  input  logic                 clk,
  input  logic                 rst,
  input  itoa_pkg::conv_out_t  conv,
  output logic                 conv_take,
  output logic                 chr_valid,
  input  logic                 chr_stall,
  output itoa_pkg::chr_t       chr
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SKIP = 2'd1;
  localparam logic [1:0] ST_SEND = 2'd2;

  logic [1:0]      state;
  logic [1:0]      state_next;
  itoa_pkg::bcd_t  digits;
  itoa_pkg::bcd_t  digits_next;
  itoa_pkg::rem_t  rem;
  itoa_pkg::rem_t  rem_next;
  logic            neg;
  logic            neg_next;
  logic [3:0]      top_digit;
  logic            can_emit;
  logic            emit;
  itoa_pkg::chr_t  emit_chr;

  assign top_digit = digits[itoa_pkg::BCD_W-1 -: 4];
  assign can_emit  = !chr_valid || !chr_stall;
  assign conv_take = (state == ST_IDLE) && conv.valid;

  always_comb begin
    state_next  = state;
    digits_next = digits;
    rem_next    = rem;
    neg_next    = neg;
    emit        = 1'b0;
    emit_chr    = '{character: itoa_pkg::GLYPHS[top_digit], last: 1'b0};
    unique case (state)
      ST_IDLE: begin
        if (conv_take) begin
          digits_next = conv.digits;
          neg_next    = conv.neg;
          rem_next    = itoa_pkg::rem_t'(itoa_pkg::DEC_DIGITS);
          state_next  = ST_SKIP;
        end
      end
      // drop leading zeros one digit a cycle, keeping at least one digit
      ST_SKIP: begin
        if (top_digit == 4'd0 && rem != itoa_pkg::rem_t'(1)) begin
          digits_next = {digits[itoa_pkg::BCD_W-5:0], 4'd0};
          rem_next    = rem - itoa_pkg::rem_t'(1);
        end else begin
          state_next = ST_SEND;
        end
      end
      ST_SEND: begin
        if (can_emit) begin
          emit = 1'b1;
          if (neg) begin
            emit_chr.character = itoa_pkg::MINUS_CHAR;
            neg_next           = 1'b0;
          end else begin
            emit_chr.last = (rem == itoa_pkg::rem_t'(1));
            digits_next   = {digits[itoa_pkg::BCD_W-5:0], 4'd0};
            rem_next      = rem - itoa_pkg::rem_t'(1);
            if (rem == itoa_pkg::rem_t'(1)) begin
              state_next = ST_IDLE;
            end
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      chr_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        chr_valid <= 1'b1;
      end else if (!chr_stall) begin
        chr_valid <= 1'b0;
      end
    end
    if (emit) begin
      chr <= emit_chr;
    end
    digits <= digits_next;
    rem    <= rem_next;
    neg    <= neg_next;
  end

  a_send_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEND) |-> (rem != '0))
    else $error("sending with no digits left");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (emit && emit_chr.last) |=> (state == ST_IDLE))
    else $error("emitter busy after final character");

  a_sign_first: assert property (@(posedge clk) disable iff (rst)
    (emit && neg) |-> !emit_chr.last)
    else $error("minus sign marked as final character");

endmodule

// ===== sv/integer_to_ascii_digits_top.sv =====
// Integer to ASCII converter. Each num item carries a 64-bit value, a base choice and a
// signed flag; the block returns its text one chr item per character, most significant
// digit first, with last set on the final character ('-' leads a negative signed decimal).
// Decimal conversion is a bit-serial double dabble; the digit shifter then walks all 20 digit
// positions, dropping leading zeros and sending one character per cycle while the output
// does not stall. The converter takes the next item while the previous text is still being
// sent; output stalls stretch the sending side.
module integer_to_ascii_digits_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            num_valid,
  output logic            num_stall,
  input  itoa_pkg::num_t  num,
  output logic            chr_valid,
  input  logic            chr_stall,
  output itoa_pkg::chr_t  chr
);

  itoa_pkg::conv_out_t conv;
  logic                conv_take;

  itoa_conv u_conv (
    .clk       (clk),
    .rst       (rst),
    .num_valid (num_valid),
    .num_stall (num_stall),
    .num       (num),
    .conv      (conv),
    .conv_take (conv_take)
  );

  itoa_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .conv      (conv),
    .conv_take (conv_take),
    .chr_valid (chr_valid),
    .chr_stall (chr_stall),
    .chr       (chr)
  );

endmodule
